>>> rtl/core/kce_pkg.sv
// Shared types, codes and constants of the k-means clustering engine.
`default_nettype none
package kce_pkg;
	localparam int DEF_MAX_POINTS   = 4096;
	localparam int DEF_MAX_CLUSTERS = 16;
	localparam int DEF_MAX_DIMS     = 16;
	localparam int DEF_RAND_LIMIT   = 32767;

	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_INC = 32'd12345;

	localparam int DIM_IDX_W = 6;
	localparam int CLU_IDX_W = 6;
	localparam int CLU_CNT_W = 7;
	localparam int SUM_W     = 44;
	localparam int DVS_W     = 32;

	localparam logic [2:0] REG_NUM_CLUSTERS = 3'd0;
	localparam logic [2:0] REG_NUM_DIMS     = 3'd1;
	localparam logic [2:0] REG_NUM_POINTS   = 3'd2;
	localparam logic [2:0] REG_THRESHOLD    = 3'd3;
	localparam logic [2:0] REG_MAX_ITER     = 3'd4;
	localparam logic [2:0] REG_SEED         = 3'd5;

	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_RUN     = 2'd1,
		KIND_RD_LBL  = 2'd2,
		KIND_RD_CEN  = 2'd3
	} kce_kind_t;

	typedef enum logic [1:0] {
		MODE_COPY = 2'd0,
		MODE_DIST = 2'd1,
		MODE_ADD  = 2'd2
	} kce_mode_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_INIT, S_GEN, S_RGO, S_RWAIT, S_NGO, S_NWAIT,
		S_COPY, S_CDRAIN, S_PASS, S_DIST, S_DWAIT, S_ACC, S_ADRAIN,
		S_UCHK, S_UGO, S_UWAIT, S_UWR, S_USQ, S_UADD, S_UEND, S_FIN
	} kce_state_t;

	typedef struct packed {
		logic                 clr_acc;
		logic                 dist_v;
		logic                 add_v;
		logic                 clr_sum;
		logic                 cnt_inc;
		logic                 cen_we;
		logic [DIM_IDX_W-1:0] dim;
		logic [CLU_IDX_W-1:0] sel;
		logic [CLU_CNT_W-1:0] k;
	} kce_ctrl_t;
endpackage
`default_nettype wire

>>> rtl/core/kce_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module kce_div import kce_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] dvd,
	input  wire logic [DVS_W-1:0] dvs,
	output logic                  busy,
	output logic                  done,
	output logic [SUM_W-1:0]      quo,
	output logic [DVS_W-1:0]      rem
);
	localparam int CNT_W = $clog2(SUM_W);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] q_q;
	logic [DVS_W-1:0] r_q, b_q;
	logic [DVS_W:0]   rs, rd;
	logic             ge;

	assign rs = {r_q, q_q[SUM_W-1]};
	assign ge = rs >= {1'b0, b_q};
	assign rd = rs - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dvd;
			r_q <= '0;
			b_q <= dvs;
		end else if (busy_q) begin
			q_q <= {q_q[SUM_W-2:0], ge};
			r_q <= ge ? rd[DVS_W-1:0] : rs[DVS_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;
endmodule
`default_nettype wire

>>> rtl/core/kce_cell.sv
// One cluster cell: centroid, distance pipeline, sums and best-match chain stage.
`default_nettype none
module kce_cell import kce_pkg::*; #(
	parameter int MAX_DIMS = DEF_MAX_DIMS,
	parameter int CELL_ID  = 0,
	parameter int CW       = 4,
	parameter int PNW      = 13
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kce_ctrl_t          ctl,
	input  wire logic signed [31:0] pt,
	input  wire logic signed [31:0] wdata,
	input  wire logic [63:0]        in_dist,
	input  wire logic [CW-1:0]      in_idx,
	output logic [63:0]             out_dist,
	output logic [CW-1:0]           out_idx,
	output logic signed [31:0]      cen_rd,
	output logic signed [SUM_W-1:0] sum_rd,
	output logic [PNW-1:0]          cnt
);
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DD = 2 ** DW;

	logic [DW-1:0]            dix;
	logic                     hit, act;
	logic signed [31:0]       cen_q [DD];
	logic signed [SUM_W-1:0]  sum_q [DD];
	logic [PNW-1:0]           cnt_q;
	logic signed [32:0]       dif;
	logic [31:0]              mag;
	logic [31:0]              mag_s2;
	logic                     v_s2, v_s3;
	logic [63:0]              sq_s3, acc_q, out_dist_q;
	logic [64:0]              accn;
	logic [CW-1:0]            out_idx_q;

	assign dix    = ctl.dim[DW-1:0];
	assign hit    = ctl.sel == CLU_IDX_W'(CELL_ID);
	assign act    = CLU_CNT_W'(CELL_ID) < ctl.k;
	assign cen_rd = cen_q[dix];
	assign sum_rd = sum_q[dix];
	assign dif    = 33'(pt) - 33'(cen_rd);
	assign mag    = dif[32] ? 32'(-dif) : dif[31:0];
	assign accn   = {1'b0, acc_q} + {1'b0, sq_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			cnt_q <= '0;
			for (int i = 0; i < DD; i++) begin
				cen_q[i] <= '0;
			end
		end else begin
			v_s2 <= ctl.dist_v;
			v_s3 <= v_s2;
			if (ctl.clr_sum) begin
				cnt_q <= '0;
			end else if (ctl.cnt_inc && hit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctl.cen_we && hit) begin
				cen_q[dix] <= wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= mag;
		sq_s3  <= mag_s2 * mag_s2;
		if (ctl.clr_acc) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= accn[64] ? '1 : accn[63:0];
		end
		if (act && (acc_q < in_dist)) begin
			out_dist_q <= acc_q;
			out_idx_q  <= CW'(CELL_ID);
		end else begin
			out_dist_q <= in_dist;
			out_idx_q  <= in_idx;
		end
		if (ctl.clr_sum) begin
			for (int i = 0; i < DD; i++) begin
				sum_q[i] <= '0;
			end
		end else if (ctl.add_v && hit) begin
			sum_q[dix] <= sum_q[dix] + SUM_W'(pt);
		end
	end

	assign out_dist = out_dist_q;
	assign out_idx  = out_idx_q;
	assign cnt      = cnt_q;
endmodule
`default_nettype wire

>>> rtl/core/kmeans_clustering_engine.sv
// Top level of the k-means clustering engine: control, stores and cell row.
//
// Command channel: a word is taken when start is high and busy is low.
// kind selects load coordinate, run clustering, read label or read centroid.
// Every word gives one result word on the result ports, flagged by
// result_valid for exactly one cycle; the receiver cannot stall it.
// Load and read words can be issued back to back; their result appears
// in the cycle after acceptance.
// A run word keeps busy high until its result: each centroid seed takes one
// serial division, each pass assigns every point through the cell row, and
// each non-empty cluster's mean is computed one dimension at a time by the
// shared serial divider.
// Configuration words use cfg_valid/cfg_ready and are always ready.
// After reset busy stays high while the label store is swept to zero;
// configuration writes are still taken then.
`default_nettype none
module kmeans_clustering_engine import kce_pkg::*; #(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_DIMS     = DEF_MAX_DIMS,
	parameter int RAND_LIMIT   = DEF_RAND_LIMIT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] coordinate,
	input  wire logic [11:0]        point_index,
	input  wire logic [3:0]         cluster_index,
	input  wire logic [3:0]         dim_index,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic                    result_valid,
	output logic [15:0]             iterations_done,
	output logic                    converged,
	output logic [3:0]              label,
	output logic signed [31:0]      centroid_value
);
	localparam int PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int PNW  = $clog2(MAX_POINTS + 1);
	localparam int DNW  = $clog2(MAX_DIMS + 1);
	localparam int KW   = $clog2(MAX_CLUSTERS + 1);
	localparam int WAIT_N = MAX_CLUSTERS + 4;
	localparam int WW   = $clog2(WAIT_N + 1);
	localparam logic [DVS_W-1:0] RMOD = DVS_W'(RAND_LIMIT) + DVS_W'(1);
	localparam logic [63:0] RDIV = 64'(RAND_LIMIT) + 64'd1;
	localparam logic [32:0] RREC = 33'(((64'd1 << 32) / RDIV) + 64'd1);

	kce_state_t state_q, state_d;

	logic [4:0]  nclu_q, ndim_q;
	logic [12:0] npts_cfg_q;
	logic [31:0] thr_q, seed_q;
	logic [15:0] maxit_q;

	logic [KW-1:0]  k_q, c_q, k_cl;
	logic [DNW-1:0] dims_q, d_q, d_cl;
	logic [PNW-1:0] npts_q, p_q, idx_q, n_cl;
	logic [PW-1:0]  clr_q;
	logic [WW-1:0]  wait_q;
	logic [15:0]    lim_q, iter_q, iters_q;
	logic [16:0]    iter_n;
	logic [63:0]    thr2_q, move_q, sq_q;
	logic [64:0]    moven;
	logic [31:0]    st_q, rnd_q, dmag_q;
	logic signed [32:0] mdif;
	logic           fail_q, conv_q, neg_q;
	logic [CW-1:0]  best_q;
	logic [48:0]    rprod;
	logic [15:0]    rquo;
	logic [31:0]    rrem;

	logic signed [31:0] pmem [MAX_POINTS * (2 ** DW)];
	logic [3:0]         lmem [MAX_POINTS];
	logic signed [31:0] pt_s1;
	logic [DNW-1:0]     rd_d_s1;
	logic               rd_v_s1;
	kce_mode_t          mode_s1, rd_mode;
	logic               rd_issue;
	logic [PW+DW-1:0]   rd_addr;

	logic               acc_w;
	logic               res_v_q, lbl_sel_q;
	logic [3:0]         lbl_rd_q;
	logic signed [31:0] cen_out_q;
	logic               fin_done;

	logic               div_start, div_busy, div_done;
	logic [SUM_W-1:0]   div_a, div_quo;
	logic [DVS_W-1:0]   div_b, div_rem;
	logic signed [SUM_W-1:0] cur_sum;
	logic [SUM_W-1:0]   cur_mag;
	logic signed [31:0] newv, wdata;

	kce_ctrl_t          ctl;
	logic [63:0]        ch_dist [MAX_CLUSTERS+1];
	logic [CW-1:0]      ch_idx  [MAX_CLUSTERS+1];
	logic signed [31:0] cen_all [MAX_CLUSTERS];
	logic signed [SUM_W-1:0] sum_all [MAX_CLUSTERS];
	logic [PNW-1:0]     cnt_all [MAX_CLUSTERS];

	assign acc_w     = start && !busy;
	assign cfg_ready = 1'b1;
	assign iter_n    = 17'(iter_q) + 17'd1;
	assign fin_done  = !fail_q || (iter_n >= 17'(lim_q));
	assign cur_sum   = sum_all[c_q[CW-1:0]];
	assign cur_mag   = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : cur_sum;
	assign newv      = neg_q ? 32'(-div_quo) : div_quo[31:0];
	assign mdif      = 33'(newv) - 33'(cen_all[c_q[CW-1:0]]);
	assign moven     = {1'b0, move_q} + {1'b0, sq_q};
	assign rprod     = 49'(st_q[31:16]) * 49'(RREC);
	assign rquo      = (RDIV > 64'd65535) ? 16'd0 : rprod[47:32];
	assign rrem      = 32'(st_q[31:16]) - 32'(rquo) * RMOD;

	assign k_cl = (nclu_q == '0) ? KW'(1) :
		((32'(nclu_q) > MAX_CLUSTERS) ? KW'(MAX_CLUSTERS) : KW'(nclu_q));
	assign d_cl = (ndim_q == '0) ? DNW'(1) :
		((32'(ndim_q) > MAX_DIMS) ? DNW'(MAX_DIMS) : DNW'(ndim_q));
	assign n_cl = (npts_cfg_q == '0) ? PNW'(1) :
		((32'(npts_cfg_q) > MAX_POINTS) ? PNW'(MAX_POINTS) : PNW'(npts_cfg_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nclu_q     <= 5'd2;
			ndim_q     <= 5'd2;
			npts_cfg_q <= 13'd1;
			thr_q      <= '0;
			maxit_q    <= 16'd100;
			seed_q     <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NUM_CLUSTERS: nclu_q     <= cfg_data[4:0];
				REG_NUM_DIMS:     ndim_q     <= cfg_data[4:0];
				REG_NUM_POINTS:   npts_cfg_q <= cfg_data[12:0];
				REG_THRESHOLD:    thr_q      <= cfg_data;
				REG_MAX_ITER:     maxit_q    <= cfg_data[15:0];
				REG_SEED:         seed_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (clr_q == PW'(MAX_POINTS - 1)) state_d = S_IDLE;
			S_IDLE:   if (acc_w && kind == KIND_RUN) state_d = S_INIT;
			S_INIT:   state_d = S_GEN;
			S_GEN:    state_d = S_RGO;
			S_RGO:    state_d = S_NGO;
			S_NGO:    state_d = S_NWAIT;
			S_NWAIT:  if (div_done) state_d = S_COPY;
			S_COPY:   if (d_q == dims_q - 1'b1) state_d = S_CDRAIN;
			S_CDRAIN: state_d = (c_q + 1'b1 < k_q) ? S_GEN : S_PASS;
			S_PASS:   state_d = S_DIST;
			S_DIST:   if (d_q == dims_q - 1'b1) state_d = S_DWAIT;
			S_DWAIT:  if (wait_q == WW'(WAIT_N - 1)) state_d = S_ACC;
			S_ACC:    if (d_q == dims_q - 1'b1) state_d = S_ADRAIN;
			S_ADRAIN: state_d = (p_q + 1'b1 < npts_q) ? S_DIST : S_UCHK;
			S_UCHK: begin
				if (cnt_all[c_q[CW-1:0]] != '0) state_d = S_UGO;
				else state_d = (c_q + 1'b1 < k_q) ? S_UCHK : S_FIN;
			end
			S_UGO:    state_d = S_UWAIT;
			S_UWAIT:  if (div_done) state_d = S_UWR;
			S_UWR:    state_d = S_USQ;
			S_USQ:    state_d = S_UADD;
			S_UADD:   state_d = (d_q + 1'b1 < dims_q) ? S_UGO : S_UEND;
			S_UEND:   state_d = (c_q + 1'b1 < k_q) ? S_UCHK : S_FIN;
			S_FIN:    state_d = fin_done ? S_IDLE : S_PASS;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy      = state_q != S_IDLE;
		rd_issue  = 1'b0;
		rd_mode   = MODE_DIST;
		div_start = 1'b0;
		div_a     = '0;
		div_b     = '0;
		rd_addr   = {p_q[PW-1:0], d_q[DW-1:0]};
		case (state_q)
			S_NGO: begin
				div_start = 1'b1;
				div_a     = SUM_W'(rnd_q);
				div_b     = DVS_W'(npts_q);
			end
			S_UGO: begin
				div_start = 1'b1;
				div_a     = cur_mag;
				div_b     = DVS_W'(cnt_all[c_q[CW-1:0]]);
			end
			S_COPY: begin
				rd_issue = 1'b1;
				rd_mode  = MODE_COPY;
				rd_addr  = {idx_q[PW-1:0], d_q[DW-1:0]};
			end
			S_DIST: begin
				rd_issue = 1'b1;
				rd_mode  = MODE_DIST;
			end
			S_ACC: begin
				rd_issue = 1'b1;
				rd_mode  = MODE_ADD;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctl         = '0;
		ctl.clr_acc = state_q == S_DIST && d_q == '0;
		ctl.dist_v  = rd_v_s1 && mode_s1 == MODE_DIST;
		ctl.add_v   = rd_v_s1 && mode_s1 == MODE_ADD;
		ctl.clr_sum = state_q == S_PASS;
		ctl.cnt_inc = state_q == S_ACC && d_q == '0;
		ctl.cen_we  = (rd_v_s1 && mode_s1 == MODE_COPY) || state_q == S_UWR;
		ctl.k       = CLU_CNT_W'(k_q);
		if (!busy) begin
			ctl.dim = DIM_IDX_W'(dim_index);
		end else if (rd_v_s1) begin
			ctl.dim = DIM_IDX_W'(rd_d_s1);
		end else begin
			ctl.dim = DIM_IDX_W'(d_q);
		end
		if (state_q == S_ACC || state_q == S_ADRAIN) begin
			ctl.sel = CLU_IDX_W'(best_q);
		end else if (!busy) begin
			ctl.sel = CLU_IDX_W'(cluster_index);
		end else begin
			ctl.sel = CLU_IDX_W'(c_q);
		end
	end

	assign wdata = (state_q == S_UWR) ? newv : pt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			rd_v_s1   <= 1'b0;
			res_v_q   <= 1'b0;
			lbl_sel_q <= 1'b0;
			cen_out_q <= '0;
			iters_q   <= '0;
			conv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_issue;
			res_v_q <= (acc_w && kind != KIND_RUN) || (state_q == S_FIN && fin_done);
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			lbl_sel_q <= acc_w && kind == KIND_RD_LBL && 32'(point_index) < MAX_POINTS;
			if (acc_w) begin
				cen_out_q <= (kind == KIND_RD_CEN && 32'(cluster_index) < MAX_CLUSTERS &&
					32'(dim_index) < MAX_DIMS) ? cen_all[CW'(cluster_index)] : '0;
			end else if (state_q == S_FIN) begin
				cen_out_q <= '0;
			end
			if (state_q == S_FIN && fin_done) begin
				iters_q <= iter_n[15:0];
				conv_q  <= !fail_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= rd_mode;
		rd_d_s1 <= d_q;
		pt_s1   <= pmem[rd_addr];
		lbl_rd_q <= lmem[PW'(point_index)];
		if (acc_w && kind == KIND_LOAD && 32'(point_index) < MAX_POINTS &&
			32'(dim_index) < MAX_DIMS) begin
			pmem[{PW'(point_index), DW'(dim_index)}] <= coordinate;
		end
		if (state_q == S_CLEAR) begin
			lmem[clr_q] <= '0;
		end else if (state_q == S_ACC && d_q == '0) begin
			lmem[p_q[PW-1:0]] <= 4'(best_q);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT: begin
				k_q    <= k_cl;
				dims_q <= d_cl;
				npts_q <= n_cl;
				lim_q  <= (maxit_q == '0) ? 16'd1 : maxit_q;
				thr2_q <= thr_q * thr_q;
				st_q   <= seed_q;
				c_q    <= '0;
				iter_q <= '0;
			end
			S_GEN:   st_q <= st_q * LCG_MUL + LCG_INC;
			S_RGO:   rnd_q <= rrem;
			S_NWAIT: begin
				if (div_done) begin
					idx_q <= PNW'(div_rem);
					d_q   <= '0;
				end
			end
			S_COPY:   d_q <= d_q + 1'b1;
			S_CDRAIN: c_q <= c_q + 1'b1;
			S_PASS: begin
				p_q    <= '0;
				d_q    <= '0;
				fail_q <= 1'b0;
			end
			S_DIST: begin
				d_q    <= d_q + 1'b1;
				wait_q <= '0;
			end
			S_DWAIT: begin
				wait_q <= wait_q + 1'b1;
				best_q <= ch_idx[MAX_CLUSTERS];
				d_q    <= '0;
			end
			S_ACC: d_q <= d_q + 1'b1;
			S_ADRAIN: begin
				p_q <= p_q + 1'b1;
				d_q <= '0;
				c_q <= '0;
			end
			S_UCHK: begin
				move_q <= '0;
				d_q    <= '0;
				if (cnt_all[c_q[CW-1:0]] == '0) begin
					c_q <= c_q + 1'b1;
				end
			end
			S_UGO: neg_q <= cur_sum[SUM_W-1];
			S_UWR: dmag_q <= mdif[32] ? 32'(-mdif) : mdif[31:0];
			S_USQ: sq_q <= dmag_q * dmag_q;
			S_UADD: begin
				move_q <= moven[64] ? '1 : moven[63:0];
				d_q    <= d_q + 1'b1;
			end
			S_UEND: begin
				if (move_q > thr2_q) fail_q <= 1'b1;
				c_q <= c_q + 1'b1;
			end
			S_FIN: begin
				iter_q <= iter_n[15:0];
				c_q    <= '0;
			end
			default: begin
			end
		endcase
	end

	kce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_a),
		.dvs    (div_b),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign ch_dist[0] = '1;
	assign ch_idx[0]  = '0;

	for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
		kce_cell #(
			.MAX_DIMS (MAX_DIMS),
			.CELL_ID  (g),
			.CW       (CW),
			.PNW      (PNW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.pt       (pt_s1),
			.wdata    (wdata),
			.in_dist  (ch_dist[g]),
			.in_idx   (ch_idx[g]),
			.out_dist (ch_dist[g+1]),
			.out_idx  (ch_idx[g+1]),
			.cen_rd   (cen_all[g]),
			.sum_rd   (sum_all[g]),
			.cnt      (cnt_all[g])
		);
	end

	assign result_valid    = res_v_q;
	assign iterations_done = iters_q;
	assign converged       = conv_q;
	assign label           = lbl_sel_q ? lbl_rd_q : 4'd0;
	assign centroid_value  = cen_out_q;

`ifndef SYNTHESIS
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(start && !busy) || $past(state_q == S_FIN)))
		else $error("result word without a cause");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");
	a_dist_dim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIST || state_q == S_ACC || state_q == S_COPY) |-> d_q < dims_q)
		else $error("dimension counter out of range");
	a_label_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(label != 4'd0) |-> result_valid)
		else $error("label driven outside a result word");
`endif
endmodule
`default_nettype wire

>>> test/testbench.sv
// Testbench for the k-means clustering engine: directed and random commands checked against a predictor.
`default_nettype none
module testbench import kce_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS_MAX   = 4096;
	localparam int NCLU_MAX   = 16;
	localparam int NDIM_MAX   = 16;
	localparam int STALL_LIMIT = 2000000;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic [15:0]        iters;
		logic               conv;
		logic [3:0]         lbl;
		logic signed [31:0] cval;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = KIND_RD_LBL;
	logic signed [31:0] coordinate = '0;
	logic [11:0] point_index = '0;
	logic [3:0] cluster_index = '0;
	logic [3:0] dim_index = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic result_valid;
	logic [15:0] iterations_done;
	logic converged;
	logic [3:0] label;
	logic signed [31:0] centroid_value;

	kmeans_clustering_engine uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.coordinate(coordinate), .point_index(point_index),
		.cluster_index(cluster_index), .dim_index(dim_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid),
		.iterations_done(iterations_done), .converged(converged), .label(label),
		.centroid_value(centroid_value)
	);

	always #5 clk = ~clk;

	// predictor state
	logic signed [31:0] pts [0:NPTS_MAX*NDIM_MAX-1];
	bit written [0:NPTS_MAX*NDIM_MAX-1];
	logic [3:0] lbls [0:NPTS_MAX-1];
	logic signed [31:0] cents [0:NCLU_MAX*NDIM_MAX-1];
	logic signed [31:0] prev_cents [0:NCLU_MAX*NDIM_MAX-1];
	longint sums [0:NCLU_MAX*NDIM_MAX-1];
	int counts [0:NCLU_MAX-1];
	logic [31:0] k_reg = 2, dims_reg = 2, npts_reg = 1, thresh_reg = 0, iter_reg = 100;
	logic [31:0] seed_reg = 1, lcg = 1;
	logic [15:0] last_iters = 0;
	logic last_conv = 0;

	outcome_t pending [$];
	int errors = 0;
	int stall_cycles = 0;
	bit calm = 0;

	function automatic longint unsigned sat_add(longint unsigned s, longint unsigned q);
		return (s > 64'hFFFF_FFFF_FFFF_FFFF - q) ? 64'hFFFF_FFFF_FFFF_FFFF : s + q;
	endfunction

	function automatic longint unsigned sq_diff(logic signed [31:0] a, logic signed [31:0] b);
		longint d;
		longint unsigned m;
		d = longint'(a) - longint'(b);
		m = (d < 0) ? longint'(-d) : d;
		return m * m;
	endfunction

	function automatic int unsigned clampu(logic [31:0] v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void cluster_points();
		int unsigned k, dims, npts, lim, iter, idx, best;
		longint unsigned pdist, best_dist, bound, mv;
		bit conv;
		k = clampu(k_reg, NCLU_MAX);
		dims = clampu(dims_reg, NDIM_MAX);
		npts = clampu(npts_reg, NPTS_MAX);
		lim = (iter_reg == 0) ? 1 : iter_reg;
		bound = longint'(thresh_reg) * longint'(thresh_reg);
		lcg = seed_reg;
		for (int c = 0; c < k; c++) begin
			lcg = lcg * 32'd1103515245 + 32'd12345;
			idx = ((lcg >> 16) % 32768) % npts;
			for (int d = 0; d < dims; d++)
				cents[c*NDIM_MAX+d] = pts[idx*NDIM_MAX+d];
		end
		iter = 0;
		do begin
			prev_cents = cents;
			foreach (sums[i]) sums[i] = 0;
			foreach (counts[i]) counts[i] = 0;
			for (int p = 0; p < npts; p++) begin
				best = 0;
				best_dist = '1;
				for (int c = 0; c < k; c++) begin
					pdist = 0;
					for (int d = 0; d < dims; d++)
						pdist = sat_add(pdist, sq_diff(pts[p*NDIM_MAX+d], cents[c*NDIM_MAX+d]));
					if (c == 0 || pdist < best_dist) begin
						best_dist = pdist;
						best = c;
					end
				end
				lbls[p] = best[3:0];
				for (int d = 0; d < dims; d++)
					sums[best*NDIM_MAX+d] += longint'(pts[p*NDIM_MAX+d]);
				counts[best]++;
			end
			for (int c = 0; c < k; c++)
				if (counts[c] != 0)
					for (int d = 0; d < dims; d++)
						cents[c*NDIM_MAX+d] = 32'(sums[c*NDIM_MAX+d] / longint'(counts[c]));
			iter++;
			conv = 1;
			for (int c = 0; c < k; c++) begin
				mv = 0;
				for (int d = 0; d < dims; d++)
					mv = sat_add(mv, sq_diff(prev_cents[c*NDIM_MAX+d], cents[c*NDIM_MAX+d]));
				if (mv > bound) conv = 0;
			end
		end while (!conv && iter < lim);
		last_iters = iter[15:0];
		last_conv = conv;
	endfunction

	function automatic outcome_t predict_command(kce_kind_t kd, logic signed [31:0] v,
			int unsigned p, int unsigned c, int unsigned d);
		outcome_t o;
		p = p & 32'hFFF;
		c = c & 32'hF;
		d = d & 32'hF;
		o.lbl = 0;
		o.cval = 0;
		case (kd)
			KIND_LOAD: begin
				pts[p*NDIM_MAX+d] = v;
				written[p*NDIM_MAX+d] = 1;
			end
			KIND_RUN: cluster_points();
			KIND_RD_LBL: o.lbl = lbls[p];
			default: o.cval = cents[c*NDIM_MAX+d];
		endcase
		o.iters = last_iters;
		o.conv = last_conv;
		return o;
	endfunction

	task automatic send_cmd(kce_kind_t kd, logic signed [31:0] v, int unsigned p,
			int unsigned c, int unsigned d);
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		kind <= kd;
		coordinate <= v;
		point_index <= p[11:0];
		cluster_index <= c[3:0];
		dim_index <= d[3:0];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending.push_back(predict_command(kd, v, p, c, d));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_NUM_CLUSTERS: k_reg = val[4:0];
			REG_NUM_DIMS: dims_reg = val[4:0];
			REG_NUM_POINTS: npts_reg = val[12:0];
			REG_THRESHOLD: thresh_reg = val;
			REG_MAX_ITER: iter_reg = val[15:0];
			REG_SEED: seed_reg = val;
			default: ;
		endcase
	endtask

	task automatic setup(logic [31:0] k, logic [31:0] dm, logic [31:0] np, logic [31:0] th,
			logic [31:0] it, logic [31:0] sd);
		drain();
		write_reg(REG_NUM_CLUSTERS, k);
		write_reg(REG_NUM_DIMS, dm);
		write_reg(REG_NUM_POINTS, np);
		write_reg(REG_THRESHOLD, th);
		write_reg(REG_MAX_ITER, it);
		write_reg(REG_SEED, sd);
	endtask

	function automatic logic signed [31:0] pick_coord(int unsigned style);
		case (style)
			0: return $urandom;
			1: return ($signed($urandom_range(0, 40)) - 20) <<< 16;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 6)) * 32'sh0030_0000 + $urandom_range(0, 255);
		endcase
	endfunction

	// load every entry a run will touch, with a mix of fresh and kept values
	task automatic fill_points(int unsigned style);
		int unsigned npts, dims;
		npts = clampu(npts_reg, NPTS_MAX);
		dims = clampu(dims_reg, NDIM_MAX);
		for (int p = 0; p < npts; p++)
			for (int d = 0; d < dims; d++)
				if (!written[p*NDIM_MAX+d] || $urandom_range(0, 3) != 0)
					send_cmd(KIND_LOAD, pick_coord(style), p, 0, d);
	endtask

	task automatic read_back(int unsigned n);
		int unsigned npts;
		npts = clampu(npts_reg, NPTS_MAX);
		repeat (n) begin
			if ($urandom_range(0, 1))
				send_cmd(KIND_RD_LBL, $urandom, $urandom_range(0, 4) == 0 ?
					$urandom_range(0, 4095) : $urandom_range(0, npts - 1), $urandom, $urandom);
			else
				send_cmd(KIND_RD_CEN, $urandom, $urandom, $urandom_range(0, 15),
					$urandom_range(0, 15));
		end
	endtask

	task automatic test_basic_ops();
		send_cmd(KIND_RD_LBL, 0, 4095, 0, 0);
		send_cmd(KIND_RD_CEN, 0, 0, 15, 15);
		send_cmd(KIND_LOAD, 32'sh7FFF_FFFF, 0, 0, 0);
		send_cmd(KIND_LOAD, 32'sh8000_0000, 0, 15, 1);
		send_cmd(KIND_LOAD, -1, 4095, 0, 15);
		send_cmd(KIND_RUN, 0, 0, 0, 0);
		send_cmd(KIND_RD_LBL, 0, 0, 0, 0);
		send_cmd(KIND_RD_CEN, 0, 0, 0, 0);
		send_cmd(KIND_RD_CEN, 0, 0, 1, 1);
		send_cmd(KIND_RD_CEN, 0, 0, 0, 1);
	endtask

	task automatic test_ties_and_empty();
		setup(3, 1, 4, 0, 10, 7);
		write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_B, 32'h1);
		for (int p = 0; p < 4; p++)
			send_cmd(KIND_LOAD, (p < 2) ? 32'sh0001_0000 : 32'sh0003_0000, p, 0, 0);
		send_cmd(KIND_RUN, 0, 0, 0, 0);
		for (int p = 0; p < 4; p++)
			send_cmd(KIND_RD_LBL, 0, p, 0, 0);
		for (int c = 0; c < 3; c++)
			send_cmd(KIND_RD_CEN, 0, 0, c, 0);
	endtask

	task automatic test_limits();
		setup(16, 16, 16, 0, 3, 32'hFFFF_FFFF);
		fill_points(2);
		send_cmd(KIND_RUN, 0, 0, 0, 0);
		read_back(12);
		setup(31, 31, 0, 32'hFFFF_FFFF, 0, 0);
		send_cmd(KIND_RUN, 0, 0, 0, 0);
		read_back(4);
		setup(0, 0, 5, 32'hFFFF_FFFF, 65535, 12345);
		fill_points(0);
		send_cmd(KIND_RUN, 0, 0, 0, 0);
		read_back(4);
	endtask

	task automatic test_full_store();
		setup(16, 1, 64, 32'h0001_0000, 1, 99);
		calm = 1;
		for (int p = 0; p < 64; p++)
			send_cmd(KIND_LOAD, pick_coord(p % 4), p, 0, 0);
		calm = 0;
		send_cmd(KIND_RUN, 0, 0, 0, 0);
		read_back(20);
	endtask

	task automatic test_random_runs(int unsigned phases);
		repeat (phases) begin
			setup($urandom_range(0, 8) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 5),
				$urandom_range(1, 4), $urandom_range(1, 12),
				$urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
				$urandom_range(1, 6), $urandom);
			calm = $urandom_range(0, 3) == 0;
			fill_points($urandom_range(0, 3));
			read_back($urandom_range(0, 3));
			send_cmd(KIND_RUN, $urandom, $urandom, $urandom, $urandom);
			read_back($urandom_range(6, 14));
			if ($urandom_range(0, 2) == 0)
				send_cmd(KIND_LOAD, $urandom, $urandom_range(16, 4095), 0, $urandom);
		end
		calm = 0;
	endtask

	task automatic test_back_to_back();
		calm = 1;
		setup(4, 3, 10, 32'h0000_8000, 8, $urandom);
		fill_points(3);
		send_cmd(KIND_RUN, 0, 0, 0, 0);
		read_back(40);
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
		if (result_valid) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word, got iters %0d", $time, iterations_done);
				errors++;
			end else begin
				e = pending.pop_front();
				if (e.iters !== iterations_done || e.conv !== converged ||
						e.lbl !== label || e.cval !== centroid_value) begin
					$display("%0t: mismatch expected iters %0d conv %0d label %0d cent %0d",
						$time, e.iters, e.conv, e.lbl, e.cval);
					$display("%0t:          actual iters %0d conv %0d label %0d cent %0d",
						$time, iterations_done, converged, label, centroid_value);
					errors++;
				end
			end
		end
	end

	initial begin
		foreach (pts[i]) begin
			pts[i] = 0;
			written[i] = 0;
		end
		foreach (lbls[i]) lbls[i] = 0;
		foreach (cents[i]) begin
			cents[i] = 0;
			prev_cents[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_ties_and_empty();
		test_limits();
		test_full_store();
		test_random_runs(44);
		test_back_to_back();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
